FILE: rtl/core/utf8d_pkg.sv
// ============================================================================
// utf8d_pkg
// Shared types and constants for the UTF-8 decoder with error policy.
// ============================================================================
package utf8d_pkg;

  // Width of the internal saturating byte counter.
  localparam int COUNT_WIDTH = 32;
  // Width of the reported byte count.
  localparam int BYTES_W     = 32;
  localparam int CP_W        = 21;

  // Result queue, depth must be a power of two.
  localparam int QDEPTH  = 4;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Error policy codes.
  localparam logic [1:0] MODE_REPLACE = 2'd0;
  localparam logic [1:0] MODE_COPY    = 2'd1;
  localparam logic [1:0] MODE_STOP    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DECODED   = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_STOPPED   = 2'd2;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(32'hFFFD);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [1:0]         status;
    logic               run_end;
    logic               string_end;
    logic [BYTES_W-1:0] bytes_consumed;
  } out_beat_t;

endpackage

FILE: rtl/core/utf8_decoder_with_error_policy.sv
// ============================================================================
// utf8_decoder_with_error_policy
// Byte-serial UTF-8 decoder with replace, copy or stop handling of bad input.
// ============================================================================
// Each result is registered into the result queue when its byte beat is accepted.
// Throughput: one byte per cycle while out_ready holds and each byte yields
// at most one result; a byte that yields two results (broken sequence plus a
// new one) is absorbed by the four-entry result queue.
// Reset (rst_n low, synchronous) clears the decode state, the byte count,
// the error mode (replace) and empties the result queue.
module utf8_decoder_with_error_policy (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input byte channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utf8d_pkg::in_beat_t   in_data,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8d_pkg::out_beat_t  out_data,
  // Configuration write channel (error mode).
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_data
);
  import utf8d_pkg::*;

  // Saturating add of a small count onto the byte counter. The counter never
  // exceeds its all-ones limit, so a carry out means saturation.
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] t,
                                                     input logic [2:0] n);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, t} + (COUNT_WIDTH + 1)'(n);
    return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Decode state. exp_r is the number of continuation bytes the pending
  // sequence needs (zero when nothing is pending), taken_r how many arrived.
  // --------------------------------------------------------------------------
  logic [1:0]             mode_r;
  logic [CP_W-1:0]        pv_r,     pv_nxt;
  logic [1:0]             exp_r,    exp_nxt;
  logic [1:0]             taken_r,  taken_nxt;
  logic [7:0]             lead_r,   lead_nxt;
  logic [COUNT_WIDTH-1:0] total_r,  total_nxt;
  logic                   halted_r, halted_nxt;

  // Result queue.
  out_beat_t              q_r [QDEPTH];
  logic [QIDX_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]      cnt_r,    cnt_nxt;

  logic in_fire;
  logic out_fire;

  // The queue always has room for the two results a byte can cause.
  assign in_ready  = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign out_fire  = out_valid && out_ready;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Single-pass decode of one byte.
  // --------------------------------------------------------------------------
  logic [7:0]             b;
  logic                   last;
  logic                   pend;
  logic                   cont;
  logic                   stop_mode;
  logic [1:0]             taken_inc;
  logic                   complete;
  logic [2:0]             n_first;
  logic [COUNT_WIDTH-1:0] t_first;
  logic [COUNT_WIDTH-1:0] t_second;
  logic [CP_W-1:0]        pv_shift;
  logic [CP_W-1:0]        sub_lead;
  logic [CP_W-1:0]        sub_byte;
  logic                   fresh;
  logic                   stopped;
  out_beat_t              res_a, res_b, res_f;
  logic                   a_vld, b_vld, f_vld;

  assign b         = in_data.data_byte;
  assign last      = in_data.end_of_input;
  assign pend      = (exp_r != 2'd0);
  assign cont      = (b[7:6] == 2'b10);
  assign stop_mode = (mode_r == MODE_STOP);
  assign taken_inc = taken_r + 2'd1;
  assign complete  = (taken_inc >= exp_r);
  assign pv_shift  = {pv_r[CP_W-7:0], b[5:0]};
  // Copy mode returns the lead byte or the current byte; replace and the unused code give U+FFFD.
  assign sub_lead  = (mode_r == MODE_COPY) ? CP_W'(lead_r) : REPLACEMENT_CP;
  assign sub_byte  = (mode_r == MODE_COPY) ? CP_W'(b)      : REPLACEMENT_CP;

  // Bytes committed by the first event of this beat: a finished sequence,
  // a sequence cut short by end of input, or a sequence broken by this byte.
  always_comb begin
    if (!pend) begin
      n_first = 3'd0;
    end else if (cont && complete) begin
      n_first = {1'b0, exp_r} + 3'd1;
    end else if (cont) begin
      n_first = {1'b0, taken_r} + 3'd2;
    end else begin
      n_first = {1'b0, taken_r} + 3'd1;
    end
  end

  // The second count adds the byte itself when it starts something new.
  assign t_first  = sat_add(total_r, n_first);
  assign t_second = sat_add(total_r, n_first + 3'd1);

  always_comb begin
    pv_nxt     = pv_r;
    exp_nxt    = exp_r;
    taken_nxt  = taken_r;
    lead_nxt   = lead_r;
    total_nxt  = total_r;
    halted_nxt = halted_r;
    res_a      = '0;
    res_b      = '0;
    res_f      = '0;
    a_vld      = 1'b0;
    b_vld      = 1'b0;
    f_vld      = 1'b0;
    fresh      = 1'b0;
    stopped    = 1'b0;

    if (in_fire) begin
      if (halted_r) begin
        // After a stop, bytes are dropped up to the end of the string.
        if (last) begin
          halted_nxt = 1'b0;
        end
      end else begin
        if (pend && cont) begin
          pv_nxt    = pv_shift;
          taken_nxt = taken_inc;
          if (complete) begin
            res_a     = '{pv_shift, ST_DECODED, 1'b1, last, BYTES_W'(t_first)};
            a_vld     = 1'b1;
            total_nxt = t_first;
            exp_nxt   = 2'd0;
            taken_nxt = 2'd0;
          end else if (last) begin
            // Sequence truncated by the end of the string.
            a_vld = 1'b1;
            if (stop_mode) begin
              res_a   = '{'0, ST_STOPPED, 1'b1, 1'b1, BYTES_W'(total_r)};
              stopped = 1'b1;
            end else begin
              res_a     = '{sub_lead, ST_MALFORMED, 1'b1, 1'b1, BYTES_W'(t_first)};
              total_nxt = t_first;
            end
          end
        end else begin
          if (pend) begin
            // The byte broke the pending sequence.
            exp_nxt   = 2'd0;
            taken_nxt = 2'd0;
            a_vld     = 1'b1;
            if (stop_mode) begin
              res_a      = '{'0, ST_STOPPED, 1'b1, 1'b1, BYTES_W'(total_r)};
              stopped    = 1'b1;
              halted_nxt = !last;
            end else begin
              res_a     = '{sub_lead, ST_MALFORMED, 1'b0, 1'b0, BYTES_W'(t_first)};
              total_nxt = t_first;
              fresh     = 1'b1;
            end
          end else begin
            fresh = 1'b1;
          end

          if (fresh) begin
            if (b[7] == 1'b0) begin
              res_f     = '{CP_W'(b), ST_DECODED, 1'b1, last, BYTES_W'(t_second)};
              f_vld     = 1'b1;
              total_nxt = t_second;
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
              lead_nxt  = b;
              taken_nxt = 2'd0;
              if (b[7:5] == 3'b110) begin
                exp_nxt = 2'd1;
                pv_nxt  = CP_W'(b[4:0]);
              end else if (b[7:4] == 4'b1110) begin
                exp_nxt = 2'd2;
                pv_nxt  = CP_W'(b[3:0]);
              end else begin
                exp_nxt = 2'd3;
                pv_nxt  = CP_W'(b[2:0]);
              end
              if (last) begin
                // A lead as the final byte is a truncated sequence.
                exp_nxt = 2'd0;
                f_vld   = 1'b1;
                if (stop_mode) begin
                  res_f   = '{'0, ST_STOPPED, 1'b1, 1'b1, BYTES_W'(t_first)};
                  stopped = 1'b1;
                end else begin
                  res_f     = '{sub_byte, ST_MALFORMED, 1'b1, 1'b1, BYTES_W'(t_second)};
                  total_nxt = t_second;
                end
              end
            end else begin
              // A stray continuation byte or an invalid lead.
              f_vld = 1'b1;
              if (stop_mode) begin
                res_f      = '{'0, ST_STOPPED, 1'b1, 1'b1, BYTES_W'(t_first)};
                stopped    = 1'b1;
                halted_nxt = !last;
              end else begin
                res_f     = '{sub_byte, ST_MALFORMED, 1'b1, last, BYTES_W'(t_second)};
                total_nxt = t_second;
              end
            end

            // Order the results: a broken-sequence result goes first.
            if (a_vld) begin
              if (f_vld) begin
                res_b = res_f;
                b_vld = 1'b1;
              end else begin
                res_a.run_end = 1'b1;
              end
            end else begin
              res_a = res_f;
              a_vld = f_vld;
            end
          end
        end

        // A string end or a stop starts a fresh string.
        if (last || stopped) begin
          pv_nxt    = '0;
          exp_nxt   = 2'd0;
          taken_nxt = 2'd0;
          lead_nxt  = '0;
          total_nxt = '0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Queue pointer and count update.
  // --------------------------------------------------------------------------
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (a_vld) begin
      wr_ptr_nxt = wr_ptr_r + QIDX_W'(b_vld ? 2 : 1);
    end
    rd_ptr_nxt = out_fire ? rd_ptr_r + QIDX_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(a_vld) + QCNT_W'(b_vld) - QCNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_REPLACE;
      pv_r     <= '0;
      exp_r    <= 2'd0;
      taken_r  <= 2'd0;
      lead_r   <= '0;
      total_r  <= '0;
      halted_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      pv_r     <= pv_nxt;
      exp_r    <= exp_nxt;
      taken_r  <= taken_nxt;
      lead_r   <= lead_nxt;
      total_r  <= total_nxt;
      halted_r <= halted_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (a_vld) begin
      q_r[wr_ptr_r] <= res_a;
    end
    if (b_vld) begin
      q_r[wr_ptr_r + QIDX_W'(1)] <= res_b;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_halt_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (exp_r == 2'd0 && total_r == '0))
    else $error("pending state while halted");

  a_taken_below_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != 2'd0) |-> (taken_r < exp_r))
    else $error("continuation count reached expected count");

  a_string_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_input) |=> (exp_r == 2'd0 && total_r == '0 && !halted_r))
    else $error("state not cleared at end of string");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// UTF-8 decoder with error policy: self-checking testbench
// Streams byte strings into the decoder and predicts every code point beat
// it should return, including replacement, copy and stop handling of bad
// input. Each result beat is compared field by field against the oldest
// prediction while both channels stall at random.
// ============================================================================
module testbench;
  import utf8d_pkg::*;

  // Error mode 3 is not a named policy; the decoder must treat it as replace.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Far above the slowest correct run of about a thousand bytes, where each
  // byte may wait out the longest input gap and two long output stalls.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Results are registered into a four-entry result queue that has to drain.
  localparam int SETTLE_CYCLES = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: a bit-true model of the decoder plus the queue of code point
  // beats that are still owed by the design.
  // --------------------------------------------------------------------------
  class utf8_scoreboard;
    logic [1:0]      mode;
    logic [CP_W-1:0] partial;
    logic [1:0]      need;      // continuation bytes the open sequence needs
    logic [1:0]      taken;     // continuation bytes received so far
    logic [7:0]      lead;
    logic [63:0]     total;     // committed bytes of the current string
    bit              halted;    // dropping bytes after a stop
    out_beat_t       awaited[$];
    out_beat_t       step_q[$];
    int              errors;

    function new();
      mode   = MODE_REPLACE;
      halted = 1'b0;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      partial = '0;
      need    = '0;
      taken   = '0;
      lead    = '0;
      total   = '0;
    endfunction

    // Saturating add. Were COUNT_WIDTH 64, the shift would wrap to zero and the
    // limit would become all ones, which is what we want.
    function void add_count(int unsigned n);
      logic [63:0] lim;
      lim = (64'd1 << COUNT_WIDTH) - 64'd1;
      if (total > lim) total = lim;
      if (lim - total < 64'(n)) total = lim;
      else total = total + 64'(n);
    endfunction

    function void push_result(logic [CP_W-1:0] cp, logic [1:0] st, bit send);
      out_beat_t r;
      r.code_point     = cp;
      r.status         = st;
      r.run_end        = 1'b0;
      r.string_end     = send;
      r.bytes_consumed = total[BYTES_W-1:0];
      step_q.push_back(r);
    endfunction

    // One malformed sequence of len bytes. Returns 1 when the string stopped.
    function bit malformed(logic [7:0] lb, int unsigned len, bit last);
      if (mode == MODE_STOP) begin
        // The count reported is the one before the bad lead.
        push_result('0, ST_STOPPED, 1'b1);
        clear_string();
        halted = !last;
        return 1'b1;
      end
      add_count(len);
      push_result((mode == MODE_COPY) ? {13'd0, lb} : REPLACEMENT_CP, ST_MALFORMED, 1'b0);
      return 1'b0;
    endfunction

    // Called for every accepted input beat; queues the results it causes.
    function void note_byte(in_beat_t beat);
      logic [7:0]  b;
      bit          last;
      bit          stopped;
      bit          absorbed;
      int unsigned len;
      out_beat_t   r;
      b        = beat.data_byte;
      last     = beat.end_of_input;
      stopped  = 1'b0;
      absorbed = 1'b0;
      step_q.delete();

      if (halted) begin
        // Dropped silently; the end-of-input byte releases the halt.
        if (last) begin
          halted = 1'b0;
          clear_string();
        end
        return;
      end

      if (need != 0) begin
        if (b[7:6] == 2'b10) begin
          absorbed = 1'b1;
          partial  = {partial[CP_W-7:0], b[5:0]};
          taken    = taken + 2'd1;
          if (taken >= need) begin
            add_count(int'(need) + 1);
            need  = '0;
            taken = '0;
            push_result(partial, ST_DECODED, 1'b0);
          end else if (last) begin
            // Truncated at end of input: all of its bytes are consumed.
            len     = int'(taken) + 1;
            need    = '0;
            taken   = '0;
            stopped = malformed(lead, len, 1'b1);
          end
        end else begin
          // A breaking byte ends the open sequence and is decoded afresh,
          // unless the policy stops the string, which drops it.
          len     = int'(taken) + 1;
          need    = '0;
          taken   = '0;
          stopped = malformed(lead, len, last);
        end
      end

      if (!absorbed && !stopped) begin
        if (!b[7]) begin
          add_count(1);
          push_result({13'd0, b}, ST_DECODED, 1'b0);
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          lead  = b;
          taken = '0;
          if (!b[5]) begin
            need    = 2'd1;
            partial = {16'd0, b[4:0]};
          end else if (!b[4]) begin
            need    = 2'd2;
            partial = {17'd0, b[3:0]};
          end else begin
            need    = 2'd3;
            partial = {18'd0, b[2:0]};
          end
          if (last) begin
            need    = '0;
            stopped = malformed(b, 1, 1'b1);
          end
        end else begin
          stopped = malformed(b, 1, last);
        end
      end

      if (step_q.size() > 0) begin
        r = step_q.pop_back();
        r.run_end = 1'b1;
        if (last) r.string_end = 1'b1;
        step_q.push_back(r);
      end
      if (last) clear_string();
      foreach (step_q[i]) awaited.push_back(step_q[i]);
    endfunction

    // Called for every accepted result beat.
    function void check_code_point(out_beat_t got);
      out_beat_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result beat: code_point %h status %0d",
               got.code_point, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.code_point !== want.code_point) begin
        $error("code_point: expected %h, actual %h", want.code_point, got.code_point);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0b, actual %0b", want.run_end, got.run_end);
        errors++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %0b, actual %0b", want.string_end, got.string_end);
        errors++;
      end
      if (got.bytes_consumed !== want.bytes_consumed) begin
        $error("bytes_consumed: expected %0d, actual %0d",
               want.bytes_consumed, got.bytes_consumed);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the design under test. Every input starts at a known
  // value and is afterwards driven only with nonblocking assignments at the
  // rising edge.
  // --------------------------------------------------------------------------
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_beat_t   in_data   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_data  = MODE_REPLACE;
  logic       in_ready;
  logic       out_valid;
  logic       cfg_ready;
  out_beat_t  out_data;

  utf8_scoreboard sb;
  bit             steady = 1'b0;   // set for a phase without any idling
  int             cycles = 0;
  int             sent = 0;        // input beats accepted so far
  logic [7:0]     text[$];         // bytes of the string being built

  always #5 clk = ~clk;

  utf8_decoder_with_error_policy uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Monitor. All three channels are sampled at the edge where a beat is
  // accepted, so the values seen are the ones that were held before it.
  // An input beat is noted before a result of the same edge is checked;
  // results are registered, so that result never depends on it anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.mode = cfg_data;
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_code_point(out_data);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: ready for a random stretch, then stalls for a random gap.
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      hold = idle_len();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Sends one byte beat. Valid is lowered only when a gap precedes the beat,
  // so back-to-back beats keep valid high and just change the payload.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Sends the bytes in text, marking the final one as end of input if asked.
  task automatic send_text(input bit close);
    foreach (text[i]) send_byte(text[i], close && (i == text.size() - 1));
    text.delete();
  endtask

  // The sender holds off until every owed result has arrived, then a few
  // more cycles in case a byte that yields nothing is still in flight.
  // The first edge lets the monitor note the last accepted byte.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode changes happen only with the decoder idle.
  task automatic write_mode(input logic [1:0] m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Lead byte of an n-byte sequence with random payload bits.
  function automatic logic [7:0] lead_byte(int n);
    case (n)
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // Appends one token: mostly well-formed characters, otherwise a stray
  // continuation, an invalid byte, or a sequence cut short by whatever
  // follows it (or by the end of the string when it is the last token).
  function automatic void add_token();
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(1, 4);
    if (r < 72) begin
      if (k == 1) begin
        text.push_back(8'($urandom_range(0, 127)));
      end else begin
        text.push_back(lead_byte(k));
        repeat (k - 1) text.push_back(cont_byte());
      end
    end else if (r < 80) begin
      text.push_back(cont_byte());
    end else if (r < 86) begin
      text.push_back(8'($urandom_range(248, 255)));
    end else begin
      k = $urandom_range(2, 4);
      text.push_back(lead_byte(k));
      repeat ($urandom_range(0, k - 2)) text.push_back(cont_byte());
    end
  endfunction

  // One random string: usually a few tokens, sometimes a long run.
  task automatic send_string();
    int tokens;
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    repeat (tokens) add_token();
    send_text(1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0] phase_mode[8];
    int         phase_base;
    phase_mode = '{MODE_REPLACE, MODE_COPY, MODE_STOP, MODE_UNUSED,
                   MODE_COPY, MODE_STOP, MODE_REPLACE, MODE_STOP};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting in the reset mode (replace). Extremes of ASCII,
    // each sequence length including the largest 21-bit value, a stray
    // continuation, an invalid byte, a sequence broken by ASCII (two results
    // from one byte), and a sequence truncated at end of input.
    text = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF,
             8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hC3, 8'h41};
    send_text(1'b0);
    text = '{8'hE2, 8'h82};
    send_text(1'b1);

    // Copy mode: a broken 4-byte sequence gives back its lead, and a lone
    // lead as the final byte is copied as well.
    write_mode(MODE_COPY);
    text = '{8'hF0, 8'h9F, 8'h28};
    send_text(1'b0);
    text = '{8'hC5};
    send_text(1'b1);

    // Mode change in the middle of a string takes effect at the next bad
    // sequence: here the ASCII byte breaks it under stop, is itself dropped,
    // and everything up to end of input is dropped after it.
    text = '{8'hE2, 8'h82};
    send_text(1'b0);
    write_mode(MODE_STOP);
    text = '{8'h41, 8'h42, 8'h43};
    send_text(1'b1);

    // Random part: eight phases over every mode value, one without idling.
    foreach (phase_mode[p]) begin
      write_mode(phase_mode[p]);
      steady     = (p == 4);
      phase_base = sent;
      while (sent - phase_base < 116) send_string();
    end
    steady = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8_decoder_with_error_policy.sv
verif/testbench.sv
